>>> sv/nearest_center_classifier_assert.svh
// Assertion helpers shared by the classifier RTL.
// Each use expects clk and rst_n in scope.
`ifndef NEAREST_CENTER_CLASSIFIER_ASSERT_SVH
`define NEAREST_CENTER_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define NCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ncc_pkg.sv
package ncc_pkg;

  localparam int MAX_CENTERS_DEF = 16;
  localparam int MAX_DIMS_DEF    = 8;
  localparam int COORD_WIDTH_DEF = 16;

  // Beat field widths
  localparam int CENTER_IDX_W = 4;
  localparam int COORD_IDX_W  = 3;
  localparam int VALUE_W      = 16;
  localparam int BUCKET_W     = 4;

  // Distance datapath
  localparam int ACC_W = 48;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam int SQ_IN_W = ACC_W / 2;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int ACTIVE_CENTERS_W = 5;
  localparam int ACTIVE_DIMS_W    = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CENTERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS    = 1'd1;
  localparam logic [ACTIVE_CENTERS_W-1:0] ACTIVE_CENTERS_RST = 5'd16;
  localparam logic [ACTIVE_DIMS_W-1:0]    ACTIVE_DIMS_RST    = 4'd8;

  localparam logic MODE_POINT = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic                    is_point;
    logic                    in_range;
    logic                    last;
    logic [CENTER_IDX_W-1:0] ctr;
    logic [COORD_IDX_W-1:0]  dim;
    logic signed [VALUE_W-1:0] value;
  } ncc_cmd_t;

endpackage

>>> sv/ncc_if.sv
interface ncc_in_if;
  import ncc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [CENTER_IDX_W-1:0]   center_index;
  logic [COORD_IDX_W-1:0]    coord_index;
  logic signed [VALUE_W-1:0] coord_value;
  logic                      last;

  modport source (output valid, mode, center_index, coord_index, coord_value, last,
                  input ready);
  modport sink (input valid, mode, center_index, coord_index, coord_value, last,
                output ready);
endinterface

interface ncc_out_if;
  import ncc_pkg::*;
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, bucket, input ready);
  modport sink (input valid, bucket, output ready);
endinterface

>>> sv/ncc_front.sv
module ncc_front import ncc_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = MAX_DIMS_DEF
) (
  ncc_in_if.sink   in_beat,
  input  logic     full,
  output logic     push,
  output ncc_cmd_t push_cmd
);

  logic is_point;
  logic dim_ok;
  logic ctr_ok;

  assign is_point = (in_beat.mode == MODE_POINT);
  assign dim_ok   = int'(in_beat.coord_index) < MAX_DIMS;
  assign ctr_ok   = int'(in_beat.center_index) < MAX_CENTERS;

  assign in_beat.ready = !full;

  always_comb begin
    push_cmd.is_point = is_point;
    push_cmd.in_range = is_point ? dim_ok : (dim_ok && ctr_ok);
    push_cmd.last     = is_point && in_beat.last;
    push_cmd.ctr      = in_beat.center_index;
    push_cmd.dim      = in_beat.coord_index;
    push_cmd.value    = in_beat.coord_value;
  end

  // Loads outside the store are consumed and dropped here.
  assign push = in_beat.valid && !full && (is_point || push_cmd.in_range);

endmodule

>>> sv/ncc_fifo.sv
`include "nearest_center_classifier_assert.svh"

module ncc_fifo import ncc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ncc_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output ncc_cmd_t pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  ncc_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   count_r, count_nxt;

  assign full      = (count_r == NW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  `NCC_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "queue popped while empty")
  `NCC_ASSERT_IMP(a_no_overflow, push, count_r < NW'(QUEUE_DEPTH), "queue pushed while full")
  `NCC_ASSERT_NXT(a_push_counted, push && !pop, count_r != '0, "pushed beat not counted")

endmodule

>>> sv/ncc_back.sv
`include "nearest_center_classifier_assert.svh"

module ncc_back import ncc_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  ncc_cmd_t              q_cmd,
  output logic                  q_pop,
  ncc_out_if.source             out_beat
);

  localparam int CW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW    = CW + DW;
  localparam int DEPTH = MAX_CENTERS * (2 ** DW);
  localparam int MAGW  = COORD_WIDTH + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  typedef struct packed {
    logic          first_dim;
    logic          last_dim;
    logic          last_ctr;
    logic [CW-1:0] ctr;
  } tag_t;

  // configuration
  logic [ACTIVE_CENTERS_W-1:0] act_ctrs_r;
  logic [ACTIVE_DIMS_W-1:0]    act_dims_r;
  logic                        cfg_zero;
  logic [CW-1:0]               n_last;
  logic [DW-1:0]               d_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_ctrs_r <= ACTIVE_CENTERS_RST;
      act_dims_r <= ACTIVE_DIMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_CENTERS: act_ctrs_r <= cfg_data[ACTIVE_CENTERS_W-1:0];
        REG_ACTIVE_DIMS:    act_dims_r <= cfg_data[ACTIVE_DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_zero = (act_ctrs_r == '0) || (act_dims_r == '0);
  assign n_last = (int'(act_ctrs_r) > MAX_CENTERS) ? CW'(MAX_CENTERS - 1)
                                                   : CW'(act_ctrs_r - ACTIVE_CENTERS_W'(1));
  assign d_last = (int'(act_dims_r) > MAX_DIMS) ? DW'(MAX_DIMS - 1)
                                                : DW'(act_dims_r - ACTIVE_DIMS_W'(1));

  // command sequencing
  logic [1:0]              state_r, state_nxt;
  logic                    start, issue, done;
  logic                    out_valid_r, out_valid_nxt;
  logic [BUCKET_W-1:0]     out_bucket_r;
  logic [CW-1:0]           c_r, n_last_r;
  logic [DW-1:0]           d_r, d_last_r;
  logic                    walk_end;
  logic [COORD_WIDTH-1:0]  wr_val;

  assign wr_val   = COORD_WIDTH'($signed(q_cmd.value));
  assign walk_end = (d_r == d_last_r) && (c_r == n_last_r);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_cmd.last) begin
            q_pop = 1'b1;
          end else if (!out_valid_r) begin
            q_pop = 1'b1;
            start = 1'b1;
            state_nxt = cfg_zero ? ST_IDLE : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        if (walk_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      c_r      <= '0;
      d_r      <= '0;
      n_last_r <= '0;
      d_last_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        c_r      <= '0;
        d_r      <= '0;
        n_last_r <= n_last;
        d_last_r <= d_last;
      end else if (issue) begin
        if (d_r == d_last_r) begin
          d_r <= '0;
          c_r <= c_r + CW'(1);
        end else begin
          d_r <= d_r + DW'(1);
        end
      end
    end
  end

  // center store and point buffer
  logic [COORD_WIDTH-1:0] center_mem [DEPTH];
  logic [COORD_WIDTH-1:0] point_r [MAX_DIMS];
  logic [COORD_WIDTH-1:0] rd_center_r, rd_point_r;
  logic                   mem_we, pt_we;

  assign mem_we = q_pop && !q_cmd.is_point && q_cmd.in_range;
  assign pt_we  = q_pop && q_cmd.is_point && q_cmd.in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      center_mem[{CW'(q_cmd.ctr), DW'(q_cmd.dim)}] <= wr_val;
    end
    rd_center_r <= center_mem[AW'({c_r, d_r})];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      point_r[DW'(q_cmd.dim)] <= wr_val;
    end
    rd_point_r <= point_r[d_r];
  end

  // distance pipeline: read, square, accumulate, compare
  logic                    v1_r, v2_r, v3_r;
  tag_t                    t1_r, t2_r, t3_r;
  logic signed [MAGW-1:0]  diff;
  logic [MAGW-1:0]         mag;
  logic [SQ_IN_W-1:0]      mag_lo;
  logic                    mag_big;
  logic [ACC_W-1:0]        sq_prod;
  logic [ACC_W-1:0]        sq_r, acc_r, dist_r, best_dist_r;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        acc_sum;
  logic [CW-1:0]           best_idx_r, final_idx;
  logic                    take;

  assign diff = $signed({rd_point_r[COORD_WIDTH-1], rd_point_r})
              - $signed({rd_center_r[COORD_WIDTH-1], rd_center_r});
  assign mag     = diff[MAGW-1] ? MAGW'(-diff) : MAGW'(diff);
  assign mag_big = (mag >> SQ_IN_W) != '0;
  assign mag_lo  = SQ_IN_W'(mag);
  // full-width square of the SQ_IN_W-bit low part of mag
  assign sq_prod = mag_lo * mag_lo;

  assign sum     = {1'b0, acc_r} + {1'b0, sq_r};
  assign acc_sum = t2_r.first_dim ? sq_r : (sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0]);

  assign take      = (t3_r.ctr == '0) || (dist_r < best_dist_r);
  assign final_idx = take ? t3_r.ctr : best_idx_r;
  assign done      = v3_r && t3_r.last_ctr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r && t2_r.last_dim;
    end
  end

  always_ff @(posedge clk) begin
    t1_r.first_dim <= (d_r == '0);
    t1_r.last_dim  <= (d_r == d_last_r);
    t1_r.last_ctr  <= (c_r == n_last_r);
    t1_r.ctr       <= c_r;
    t2_r           <= t1_r;
    sq_r           <= mag_big ? ACC_MAX : sq_prod;
    if (v2_r) begin
      acc_r <= acc_sum;
    end
    if (v2_r && t2_r.last_dim) begin
      dist_r <= acc_sum;
      t3_r   <= t2_r;
    end
    if (v3_r && take) begin
      best_dist_r <= dist_r;
      best_idx_r  <= t3_r.ctr;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((start && cfg_zero) || done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && cfg_zero) begin
      out_bucket_r <= '0;
    end else if (done) begin
      out_bucket_r <= BUCKET_W'(final_idx);
    end
  end

  assign out_beat.valid  = out_valid_r;
  assign out_beat.bucket = out_bucket_r;

  `NCC_ASSERT_IMP(a_slot_free, done, !out_valid_r, "result would overwrite a pending beat")
  `NCC_ASSERT_IMP(a_idle_empty, state_r == ST_IDLE, !v1_r && !v2_r && !v3_r,
                  "distance pipeline busy while idle")
  `NCC_ASSERT_IMP(a_no_pop_busy, state_r != ST_IDLE, !q_pop, "command taken during a walk")
  `NCC_ASSERT_NXT(a_done_shows, done, out_valid_r, "finished walk left no result")

endmodule

>>> sv/nearest_center_classifier.sv
// Nearest-center classifier: beats with mode 0 load one coordinate of one
// center into the center store, beats with mode 1 write one coordinate of the
// point; a point beat with last set compares the point with centers
// 0..active_centers-1 over coordinates 0..active_dims-1 (squared Euclidean,
// saturating 48-bit sum) and returns the lowest index of the nearest center.
// Input beats land in a 4-entry command queue, so the input keeps flowing
// while a result waits until the queue is full. In the back end a last point
// beat walks the active centers over the active coordinates (counts clamped to
// MAX_CENTERS and MAX_DIMS; no walk when either register is zero), paced by
// the single read port of the center store (one coordinate a cycle) and the
// read/square/accumulate/compare pipeline behind it. A last beat is held in
// the queue until the result register is empty. Reading a center or point
// coordinate that was never written gives an undefined bucket.
module nearest_center_classifier import ncc_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ncc_in_if.sink                in_beat,
  ncc_out_if.source             out_beat
);

  logic     push, full, pop, pop_valid;
  ncc_cmd_t push_cmd, pop_cmd;

  ncc_front #(
    .MAX_CENTERS(MAX_CENTERS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_front (
    .in_beat (in_beat),
    .full    (full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  ncc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_valid(pop_valid),
    .pop_cmd  (pop_cmd)
  );

  ncc_back #(
    .MAX_CENTERS(MAX_CENTERS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (pop_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .out_beat (out_beat)
  );

endmodule
